[design/sdff_pkg.sv]
// ----------------------------------------------------------------------------
// sdff_pkg
// Shared types, character codes and the microcode store for the signed
// decimal field formatter.
// ----------------------------------------------------------------------------
package sdff_pkg;

  localparam int MAG_W      = 64;
  localparam int NUM_DIGITS = 20;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int ND_W       = 5;
  localparam int CNT_W      = 7;
  localparam int PC_W       = 4;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_PLUS  = 8'd43;

  // datapath operations
  localparam logic [2:0] OP_IDLE   = 3'd0;
  localparam logic [2:0] OP_DABBLE = 3'd1;
  localparam logic [2:0] OP_NORM   = 3'd2;
  localparam logic [2:0] OP_SETUP  = 3'd3;
  localparam logic [2:0] OP_LIMIT  = 3'd4;
  localparam logic [2:0] OP_LOAD   = 3'd5;
  localparam logic [2:0] OP_EMIT   = 3'd6;
  localparam logic [2:0] OP_NOP    = 3'd7;

  // output segments, in field order
  localparam logic [2:0] SEG_LEAD  = 3'd0;
  localparam logic [2:0] SEG_SIGN  = 3'd1;
  localparam logic [2:0] SEG_ZERO  = 3'd2;
  localparam logic [2:0] SEG_DIG   = 3'd3;
  localparam logic [2:0] SEG_TRAIL = 3'd4;

  // jump conditions
  localparam logic [2:0] COND_NEXT   = 3'd0;
  localparam logic [2:0] COND_ALWAYS = 3'd1;
  localparam logic [2:0] COND_WAIT   = 3'd2;
  localparam logic [2:0] COND_LOOP   = 3'd3;
  localparam logic [2:0] COND_NORM   = 3'd4;
  localparam logic [2:0] COND_EMIT   = 3'd5;

  typedef struct packed {
    logic signed [MAG_W-1:0] value;
    logic [5:0]              field_width;
    logic [5:0]              precision;
    logic                    precision_given;
    logic                    left_justify;
    logic                    zero_fill;
    logic                    force_plus;
    logic                    space_sign;
  } sdff_spec_t;

  typedef struct packed {
    logic [7:0]       character;
    logic             last_char;
    logic [CNT_W-1:0] total_length;
  } sdff_glyph_t;

  typedef struct packed {
    logic [2:0]      op;
    logic [2:0]      seg;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } sdff_ctrl_t;

  typedef struct packed {
    logic spec_valid;
    logic loop_more;
    logic norm_more;
    logic emit_more;
  } sdff_status_t;

  function automatic sdff_ctrl_t sdff_rom(input logic [PC_W-1:0] addr);
    sdff_ctrl_t w;
    w = '{op: OP_NOP, seg: SEG_LEAD, cond: COND_ALWAYS, target: 4'd0};
    unique case (addr)
      4'd0:  w = '{op: OP_IDLE,   seg: SEG_LEAD,  cond: COND_WAIT,   target: 4'd0};
      4'd1:  w = '{op: OP_DABBLE, seg: SEG_LEAD,  cond: COND_LOOP,   target: 4'd1};
      4'd2:  w = '{op: OP_NORM,   seg: SEG_LEAD,  cond: COND_NORM,   target: 4'd2};
      4'd3:  w = '{op: OP_SETUP,  seg: SEG_LEAD,  cond: COND_NEXT,   target: 4'd0};
      4'd4:  w = '{op: OP_LIMIT,  seg: SEG_LEAD,  cond: COND_NEXT,   target: 4'd0};
      4'd5:  w = '{op: OP_LOAD,   seg: SEG_LEAD,  cond: COND_NEXT,   target: 4'd0};
      4'd6:  w = '{op: OP_EMIT,   seg: SEG_LEAD,  cond: COND_EMIT,   target: 4'd6};
      4'd7:  w = '{op: OP_LOAD,   seg: SEG_SIGN,  cond: COND_NEXT,   target: 4'd0};
      4'd8:  w = '{op: OP_EMIT,   seg: SEG_SIGN,  cond: COND_EMIT,   target: 4'd8};
      4'd9:  w = '{op: OP_LOAD,   seg: SEG_ZERO,  cond: COND_NEXT,   target: 4'd0};
      4'd10: w = '{op: OP_EMIT,   seg: SEG_ZERO,  cond: COND_EMIT,   target: 4'd10};
      4'd11: w = '{op: OP_LOAD,   seg: SEG_DIG,   cond: COND_NEXT,   target: 4'd0};
      4'd12: w = '{op: OP_EMIT,   seg: SEG_DIG,   cond: COND_EMIT,   target: 4'd12};
      4'd13: w = '{op: OP_LOAD,   seg: SEG_TRAIL, cond: COND_NEXT,   target: 4'd0};
      4'd14: w = '{op: OP_EMIT,   seg: SEG_TRAIL, cond: COND_EMIT,   target: 4'd14};
      4'd15: w = '{op: OP_NOP,    seg: SEG_LEAD,  cond: COND_ALWAYS, target: 4'd0};
      default: w = '{op: OP_NOP, seg: SEG_LEAD, cond: COND_ALWAYS, target: 4'd0};
    endcase
    return w;
  endfunction

endpackage

[design/sdff_seq.sv]
// ----------------------------------------------------------------------------
// sdff_seq
// Step counter and microcode store; picks the next step from the jump
// condition of the current control word.
// ----------------------------------------------------------------------------
module sdff_seq
  import sdff_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  sdff_status_t status,
  output sdff_ctrl_t   ctrl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  assign ctrl = sdff_rom(pc);

  always_comb begin
    unique case (ctrl.cond)
      COND_NEXT:   take = 1'b0;
      COND_ALWAYS: take = 1'b1;
      COND_WAIT:   take = !status.spec_valid;
      COND_LOOP:   take = status.loop_more;
      COND_NORM:   take = status.norm_more;
      COND_EMIT:   take = status.emit_more;
      default:     take = 1'b0;
    endcase
    pc_next = take ? ctrl.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

[design/sdff_dp.sv]
// ----------------------------------------------------------------------------
// sdff_dp
// Datapath: shift-and-add-3 binary to BCD, leading zero strip, pad
// arithmetic and the character emitter, all driven by the control word.
// ----------------------------------------------------------------------------
module sdff_dp
  import sdff_pkg::*;
#(
  parameter int MAX_FIELD_CHARS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  sdff_ctrl_t   ctrl,
  input  sdff_spec_t   spec,
  input  logic         spec_valid,
  input  logic         glyph_ready,
  output sdff_status_t status,
  output logic         emit,
  output sdff_glyph_t  glyph
);

  localparam logic [CNT_W-1:0] MaxChars = CNT_W'(MAX_FIELD_CHARS);

  logic [MAG_W-1:0] mag;
  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] bcd_adj;
  logic [CNT_W-1:0] cnt;
  logic [ND_W-1:0]  nd;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] lim;
  logic [5:0]       field_width;
  logic [5:0]       precision;
  logic             precision_given;
  logic             left_justify;
  logic             zero_fill;
  logic             has_sign;
  logic [7:0]       sign_ch;
  logic [5:0]       seg_lead;
  logic [5:0]       seg_zero;
  logic [5:0]       seg_trail;

  logic [3:0]       top_digit;
  logic             emit_more;
  logic [CNT_W-1:0] seg_len;
  logic [7:0]       ch;
  logic             last;

  logic [5:0]       nd6;
  logic [5:0]       prec_eff;
  logic [5:0]       p;
  logic [6:0]       body;
  logic [6:0]       sign_nd;
  logic [5:0]       wsp;
  logic [5:0]       zfill;
  logic [5:0]       zprec;
  logic [CNT_W-1:0] total;

  assign top_digit = bcd[BCD_W-1 -: 4];

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  assign emit_more = (cnt != '0) && (pos != lim);
  assign emit      = (ctrl.op == OP_EMIT) && emit_more && glyph_ready;

  assign status.spec_valid = spec_valid;
  assign status.loop_more  = (cnt != CNT_W'(1));
  assign status.norm_more  = (top_digit == 4'd0) && (nd != ND_W'(1));
  assign status.emit_more  = emit_more;

  // pad arithmetic
  always_comb begin
    nd6      = {1'b0, nd};
    prec_eff = precision_given ? precision : 6'd0;
    p        = (nd6 > prec_eff) ? nd6 : prec_eff;
    body     = {1'b0, p} + {6'd0, has_sign};
    sign_nd  = {1'b0, nd6} + {6'd0, has_sign};
    wsp      = ({1'b0, field_width} > body) ? 6'({1'b0, field_width} - body) : 6'd0;
    zfill    = ({1'b0, field_width} > sign_nd) ? 6'({1'b0, field_width} - sign_nd) : 6'd0;
    zprec    = p - nd6;
    total    = CNT_W'(seg_lead) + CNT_W'(has_sign) + CNT_W'(seg_zero)
             + CNT_W'(nd) + CNT_W'(seg_trail);
  end

  always_comb begin
    unique case (ctrl.seg)
      SEG_LEAD:  begin seg_len = CNT_W'(seg_lead);  ch = CH_SPACE; end
      SEG_SIGN:  begin seg_len = CNT_W'(has_sign);  ch = sign_ch; end
      SEG_ZERO:  begin seg_len = CNT_W'(seg_zero);  ch = CH_ZERO; end
      SEG_DIG:   begin seg_len = CNT_W'(nd);        ch = CH_ZERO + {4'd0, top_digit}; end
      SEG_TRAIL: begin seg_len = CNT_W'(seg_trail); ch = CH_SPACE; end
      default:   begin seg_len = '0;                ch = CH_SPACE; end
    endcase
  end

  assign last               = (pos + CNT_W'(1) == lim);
  assign glyph.character    = ch;
  assign glyph.last_char    = last;
  assign glyph.total_length = last ? lim : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      pos <= '0;
      lim <= CNT_W'(1);
    end else begin
      case (ctrl.op)
        OP_IDLE: begin
          if (spec_valid) begin
            cnt <= CNT_W'(MAG_W);
          end
        end
        OP_DABBLE: cnt <= cnt - CNT_W'(1);
        OP_LIMIT: begin
          lim <= (total > MaxChars) ? MaxChars : total;
          pos <= '0;
        end
        OP_LOAD: cnt <= seg_len;
        OP_EMIT: begin
          if (emit) begin
            cnt <= cnt - CNT_W'(1);
            pos <= pos + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_IDLE: begin
        if (spec_valid) begin
          mag             <= spec.value[MAG_W-1] ? (~spec.value + 1'b1) : spec.value;
          bcd             <= '0;
          nd              <= ND_W'(NUM_DIGITS);
          field_width     <= spec.field_width;
          precision       <= spec.precision;
          precision_given <= spec.precision_given;
          left_justify    <= spec.left_justify;
          zero_fill       <= spec.zero_fill;
          has_sign        <= spec.value[MAG_W-1] | spec.force_plus | spec.space_sign;
          sign_ch         <= spec.value[MAG_W-1] ? CH_MINUS :
                             spec.force_plus     ? CH_PLUS  : CH_SPACE;
        end
      end
      OP_DABBLE: begin
        bcd <= {bcd_adj[BCD_W-2:0], mag[MAG_W-1]};
        mag <= {mag[MAG_W-2:0], 1'b0};
      end
      OP_NORM: begin
        if (status.norm_more) begin
          bcd <= {bcd[BCD_W-5:0], 4'd0};
          nd  <= nd - ND_W'(1);
        end
      end
      OP_SETUP: begin
        if (left_justify) begin
          seg_lead  <= 6'd0;
          seg_zero  <= zprec;
          seg_trail <= wsp;
        end else if (zero_fill && !precision_given) begin
          seg_lead  <= 6'd0;
          seg_zero  <= zfill;
          seg_trail <= 6'd0;
        end else begin
          seg_lead  <= wsp;
          seg_zero  <= zprec;
          seg_trail <= 6'd0;
        end
      end
      OP_EMIT: begin
        if (emit && ctrl.seg == SEG_DIG) begin
          bcd <= {bcd[BCD_W-5:0], 4'd0};
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // never more characters than the clipped field length
  a_pos_bound: assert property (@(posedge clk) disable iff (rst) pos <= lim)
    else $error("character count ran past field length");

  // all magnitude bits have been shifted into the BCD register
  a_mag_drained: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_NORM |-> mag == '0)
    else $error("magnitude not drained after conversion");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (emit && ctrl.seg == SEG_DIG) |-> top_digit <= 4'd9)
    else $error("emitted digit is not decimal");

  a_nd_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_SETUP |-> (nd != '0 && nd <= ND_W'(NUM_DIGITS)))
    else $error("digit count out of range");
`endif

endmodule

[design/signed_decimal_field_formatter.sv]
// One transaction in, one character per output transaction; the last one is marked.
// After acceptance an item passes the 64-step shift-and-add-3 conversion, the leading
// zero strip, the pad set-up and the field clip, then a load and an emission per segment;
// characters are emitted one per cycle while the output does not stall.
// A new item is taken only when the sequencer is back at its idle step.
// Synchronous reset returns the sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter
// printf-style %d field formatter: microcoded sequencer plus datapath,
// with a registered output stage.
// ----------------------------------------------------------------------------
module signed_decimal_field_formatter
  import sdff_pkg::*;
#(
  parameter int MAX_FIELD_CHARS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        spec_valid,
  output logic        spec_stall,
  input  sdff_spec_t  spec,
  output logic        glyph_valid,
  input  logic        glyph_stall,
  output sdff_glyph_t glyph
);

  sdff_ctrl_t   ctrl;
  sdff_status_t status;
  sdff_glyph_t  dp_glyph;
  logic         emit;
  logic         glyph_ready;

  assign spec_stall  = (ctrl.op != OP_IDLE);
  assign glyph_ready = !glyph_valid || !glyph_stall;

  sdff_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  sdff_dp #(
    .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .spec        (spec),
    .spec_valid  (spec_valid),
    .glyph_ready (glyph_ready),
    .status      (status),
    .emit        (emit),
    .glyph       (dp_glyph)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_valid <= 1'b0;
    end else if (emit) begin
      glyph_valid <= 1'b1;
    end else if (!glyph_stall) begin
      glyph_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      glyph <= dp_glyph;
    end
  end

endmodule
